[hw/rtl/vri_pkg.sv]
// Shared types and constants of the video register interface.
// Depends on nothing; every other file imports it.
package vri_pkg;

  localparam int OBJECT_DEPTH  = 256;
  localparam int PALETTE_DEPTH = 32;
  localparam int OBJ_AW        = $clog2(OBJECT_DEPTH);
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // command codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  // register map
  localparam logic [2:0] REG_CTRL0    = 3'd0;
  localparam logic [2:0] REG_CTRL1    = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
  localparam logic [2:0] REG_OBJ_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [6:0]  PAL_PAGE       = 7'h3F;
  localparam logic [13:0] NT_BASE        = 14'h2000;
  localparam logic [7:0]  STATUS_FIXED   = 8'h10;
  localparam logic [13:0] NT_MASK_RESET  = 14'd2047;
  localparam logic [PAL_AW-1:0] PAL_MIRROR = PAL_AW'(16);

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] vram_data;
    logic [2:0] status_flags;
  } vri_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic        vram_we;
    logic [13:0] vram_waddr;
    logic [7:0]  vram_wdata;
    logic [14:0] render_addr;
    logic [2:0]  fine_x;
    logic [7:0]  control_zero;
    logic [7:0]  control_one;
  } vri_rsp_t;

  typedef struct packed {
    logic              en;
    logic [OBJ_AW-1:0] addr;
    logic [7:0]        data;
  } vri_obj_wr_t;

endpackage

[hw/rtl/vri_req_if.sv]
// Request channel: valid/ready handshake carrying one bus access word.
// Depends on vri_pkg.
interface vri_req_if import vri_pkg::*; ();
  logic     valid;
  logic     ready;
  vri_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/vri_rsp_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on vri_pkg.
interface vri_rsp_if import vri_pkg::*; ();
  logic     valid;
  logic     ready;
  vri_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/vri_object_ram.sv]
// Object RAM: single write port, registered read, per-entry valid bits
// so unwritten entries read as zero after reset. Depends on vri_pkg.
module vri_object_ram import vri_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  vri_obj_wr_t       wr,
  input  logic              rd_en,
  input  logic [OBJ_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]              mem [OBJECT_DEPTH];
  logic [OBJECT_DEPTH-1:0] written;
  logic [7:0]              mem_q;
  logic                    hit_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = hit_q ? mem_q : 8'd0;

endmodule

[hw/rtl/vri_reg_core.sv]
// Register state and next-state logic for one bus access.
// Depends on vri_pkg; the object RAM sits outside.
module vri_reg_core import vri_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [13:0]       cfg_data,
  input  vri_req_t          item,
  input  logic              commit,
  input  logic [7:0]        obj_rdata,
  output logic [OBJ_AW-1:0] obj_rd_addr,
  output vri_obj_wr_t       obj_wr,
  output vri_rsp_t          result
);

  logic [13:0] nametable_mask;
  logic [14:0] temp_addr, temp_addr_next;
  logic [14:0] render_address, render_address_next;
  logic [14:0] access_addr, access_addr_next;
  logic        write_toggle, write_toggle_next;
  logic [2:0]  fine_x_latch, fine_x_latch_next;
  logic [7:0]  ctrl_a, ctrl_a_next;
  logic [7:0]  ctrl_b, ctrl_b_next;
  logic [OBJ_AW-1:0] object_addr, object_addr_next;
  logic [7:0]  read_buffer, read_buffer_next;
  logic        flag_vblank, flag_vblank_next;
  logic        flag_hit, flag_hit_next;
  logic        flag_overflow, flag_overflow_next;
  logic [7:0]  palette [PALETTE_DEPTH];

  logic              is_rd, is_wr;
  logic              in_pal, below_pal, in_nt;
  logic [PAL_AW-1:0] pal_idx;
  logic              pal_we;
  logic [13:0]       access_step;
  logic [7:0]        rd_byte;
  logic              we;
  logic [13:0]       waddr;
  logic [7:0]        wdata;
  logic [7:0]        d;

  assign d      = item.write_data;
  assign is_rd  = (item.command == CMD_READ);
  assign is_wr  = (item.command == CMD_WRITE);

  // palette space is 0x3F00..0x3FFF; entry 16 mirrors entry 0
  assign in_pal    = (access_addr[14:8] == PAL_PAGE);
  assign below_pal = !access_addr[14] && !in_pal;
  assign in_nt     = below_pal && access_addr[13];
  assign pal_idx   = (access_addr[PAL_AW-1:0] == PAL_MIRROR) ? '0
                                                             : access_addr[PAL_AW-1:0];
  assign access_step = access_addr[13:0] + (ctrl_a[2] ? 14'd32 : 14'd1);

  always_comb begin
    temp_addr_next      = temp_addr;
    render_address_next = render_address;
    access_addr_next    = access_addr;
    write_toggle_next   = write_toggle;
    fine_x_latch_next   = fine_x_latch;
    ctrl_a_next         = ctrl_a;
    ctrl_b_next         = ctrl_b;
    object_addr_next    = object_addr;
    read_buffer_next    = read_buffer;
    flag_vblank_next    = flag_vblank;
    flag_hit_next       = flag_hit;
    flag_overflow_next  = flag_overflow;
    obj_wr.en   = 1'b0;
    obj_wr.addr = object_addr;
    obj_wr.data = d;
    pal_we  = 1'b0;
    rd_byte = 8'd0;
    we      = 1'b0;
    waddr   = 14'd0;
    wdata   = 8'd0;
    if (item.command == CMD_STATUS) begin
      flag_vblank_next   = item.status_flags[2];
      flag_hit_next      = item.status_flags[1];
      flag_overflow_next = item.status_flags[0];
    end else if (is_rd || is_wr) begin
      case (item.reg_index)
        REG_CTRL0: begin
          if (is_wr) begin
            ctrl_a_next           = d;
            temp_addr_next[11:10] = d[1:0];
          end else begin
            rd_byte = ctrl_a;
          end
        end
        REG_CTRL1: begin
          if (is_wr) ctrl_b_next = d;
          else       rd_byte     = ctrl_b;
        end
        REG_STATUS: begin
          if (is_rd) begin
            rd_byte = {flag_vblank, flag_hit, flag_overflow, 5'd0} | STATUS_FIXED;
            flag_vblank_next  = 1'b0;
            flag_hit_next     = 1'b0;
            write_toggle_next = 1'b0;
          end
        end
        REG_OBJ_ADDR: begin
          if (is_wr) object_addr_next = d[OBJ_AW-1:0];
        end
        REG_OBJ_DATA: begin
          // the entry is written only at the edge where this word lands
          if (is_wr) obj_wr.en = commit;
          else       rd_byte   = obj_rdata;
          object_addr_next = object_addr + OBJ_AW'(1);
        end
        REG_SCROLL: begin
          if (is_wr) begin
            if (!write_toggle) begin
              fine_x_latch_next   = d[2:0];
              temp_addr_next[4:0] = d[7:3];
            end else begin
              temp_addr_next[14:12] = d[2:0];
              temp_addr_next[9:5]   = d[7:3];
            end
            write_toggle_next = ~write_toggle;
          end
        end
        REG_ADDR: begin
          if (is_wr) begin
            if (!write_toggle) begin
              access_addr_next[14:8] = d[6:0];
              temp_addr_next[13:8]   = d[5:0];
              temp_addr_next[14]     = 1'b0;
            end else begin
              access_addr_next[7:0] = d;
              temp_addr_next[7:0]   = d;
              render_address_next   = {temp_addr[14:8], d};
            end
            write_toggle_next = ~write_toggle;
          end
        end
        REG_DATA: begin
          if (is_wr) begin
            if (in_pal) begin
              pal_we = 1'b1;
            end else if (in_nt) begin
              we    = 1'b1;
              waddr = (access_addr[13:0] & nametable_mask) + NT_BASE;
              wdata = d;
            end
          end else begin
            if (in_pal) begin
              rd_byte = palette[pal_idx];
            end else if (below_pal) begin
              rd_byte          = read_buffer;
              read_buffer_next = item.vram_data;
            end
          end
          access_addr_next = {1'b0, access_step};
        end
        default: ;
      endcase
    end
  end

  // read address for the next word: the object address once this word lands
  assign obj_rd_addr = commit ? object_addr_next : object_addr;

  assign result.read_data    = rd_byte;
  assign result.vram_addr    = access_addr_next;
  assign result.vram_we      = we;
  assign result.vram_waddr   = waddr;
  assign result.vram_wdata   = wdata;
  assign result.render_addr  = render_address_next;
  assign result.fine_x       = fine_x_latch_next;
  assign result.control_zero = ctrl_a_next;
  assign result.control_one  = ctrl_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      nametable_mask <= NT_MASK_RESET;
      temp_addr      <= '0;
      render_address <= '0;
      access_addr    <= '0;
      write_toggle   <= 1'b0;
      fine_x_latch   <= '0;
      ctrl_a         <= '0;
      ctrl_b         <= '0;
      object_addr    <= '0;
      read_buffer    <= '0;
      flag_vblank    <= 1'b0;
      flag_hit       <= 1'b0;
      flag_overflow  <= 1'b0;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        palette[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        nametable_mask <= cfg_data;
      end
      if (commit) begin
        temp_addr      <= temp_addr_next;
        render_address <= render_address_next;
        access_addr    <= access_addr_next;
        write_toggle   <= write_toggle_next;
        fine_x_latch   <= fine_x_latch_next;
        ctrl_a         <= ctrl_a_next;
        ctrl_b         <= ctrl_b_next;
        object_addr    <= object_addr_next;
        read_buffer    <= read_buffer_next;
        flag_vblank    <= flag_vblank_next;
        flag_hit       <= flag_hit_next;
        flag_overflow  <= flag_overflow_next;
        if (pal_we) begin
          palette[pal_idx] <= d;
        end
      end
    end
  end

endmodule

[hw/rtl/video_register_interface.sv]
// Processor-facing register file of a tile video unit.
// Usage:
//   req  - one bus access word per handshake (valid/ready): register read,
//          register write, or a load of the renderer's status flags.
//   rsp  - exactly one result word per request word, in order: read byte,
//          access/render addresses, fine X, both control bytes and an
//          optional nametable write (vram_we, vram_waddr, vram_wdata).
//   cfg_we/cfg_data - write the nametable mask; write only while idle.
// A word accepted into the input register is committed into the output
// register once the output slot is free; its result is valid from then on.
// Throughput: one word per cycle while rsp.ready stays high. The object
// RAM is read during the accept cycle at the address left by the word
// ahead, so the input register, the register core and the output
// register form a two-stage pipe that never bubbles.
// Stalls: when rsp.ready is low the output register holds its word; one
// further word may wait in the input register, then req.ready drops.
// Reset (rst, synchronous): the valid bits, core registers, flags, palette
// and the nametable mask (to 2047) return to their reset values; object
// RAM entries read as zero until written. There is no clearing pass.
// Depends on vri_pkg, vri_req_if, vri_rsp_if, vri_object_ram, vri_reg_core.
module video_register_interface import vri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  vri_req_if.sink     req,
  vri_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [13:0] cfg_data
);

  vri_req_t          item;
  logic              item_valid;
  vri_rsp_t          out_word;
  logic              out_valid;
  logic              commit;
  logic              accept;
  vri_rsp_t          result;
  vri_obj_wr_t       obj_wr;
  logic [OBJ_AW-1:0] obj_rd_addr;
  logic [7:0]        obj_rdata;

  // advance the word in the input register when the output slot is free
  assign commit     = item_valid && (!out_valid || rsp.ready);
  assign req.ready  = !item_valid || commit;
  assign accept     = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (commit) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.payload;
    end
  end

  vri_object_ram u_obj_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (obj_wr),
    .rd_en   (accept),
    .rd_addr (obj_rd_addr),
    .rd_data (obj_rdata)
  );

  vri_reg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .item        (item),
    .commit      (commit),
    .obj_rdata   (obj_rdata),
    .obj_rd_addr (obj_rd_addr),
    .obj_wr      (obj_wr),
    .result      (result)
  );

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word <= result;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  // the object RAM never reads the entry it is writing in the same cycle
  a_obj_no_collide: assert property (@(posedge clk) disable iff (rst)
    obj_wr.en && commit && accept |-> obj_wr.addr != obj_rd_addr)
    else $error("object RAM read and write collide");

  // a committed word always lands in the output register
  a_commit_lands: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed word lost");

  // a word is only committed from a full input register into a free slot
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    commit |-> item_valid && (!out_valid || rsp.ready))
    else $error("commit without a free output slot");

  // a data-port access leaves the access address inside 0x0000..0x3FFF
  a_data_wraps: assert property (@(posedge clk) disable iff (rst)
    commit && item.reg_index == REG_DATA
      && (item.command == CMD_READ || item.command == CMD_WRITE)
      |=> !out_word.vram_addr[14])
    else $error("access address escaped 14 bits");

endmodule

[dv/video_register_interface_tb.sv]
// Self-checking testbench for video_register_interface: bus words go in through
// a queue-fed driver, and every result word is checked against a register-file model.
// Depends on vri_pkg, vri_req_if, vri_rsp_if and the video_register_interface RTL.
`timescale 1ns / 1ps

module video_register_interface_tb;
  import vri_pkg::*;

  // code that the block must treat as "no operation"
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int SEGMENT_WORDS = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [13:0] cfg_data;

  vri_req_if req_ch ();
  vri_rsp_if rsp_ch ();

  video_register_interface uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Model copy of the register file. It is advanced only when a bus word is
  // accepted, so it matches the block's state once every accepted word has committed.
  logic [14:0] scroll_temp = '0;
  logic [14:0] render_reg  = '0;
  logic [14:0] acc_addr    = '0;
  logic        wr_latch    = 1'b0;
  logic [2:0]  fine_x_q    = '0;
  logic [7:0]  ctrl0_q     = '0;
  logic [7:0]  ctrl1_q     = '0;
  logic [7:0]  oam_ptr     = '0;
  logic [7:0]  oam_mem [OBJECT_DEPTH];
  logic [7:0]  pal_mem [PALETTE_DEPTH];
  logic [7:0]  rd_buf      = '0;
  logic        vblank_q    = 1'b0;
  logic        hit_q       = 1'b0;
  logic        ovf_q       = 1'b0;
  logic [13:0] nt_mask_q   = NT_MASK_RESET;

  vri_req_t bus_words [$];     // words waiting to be offered
  vri_rsp_t awaited_rsp [$];   // predicted results, oldest first

  int words_issued = 0;
  int words_sent   = 0;
  int rsp_seen     = 0;
  int nt_writes    = 0;
  int error_count  = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 86;
  int hold_left     = 0;
  int squeeze_mark  = 0;
  bit squeeze_armed = 1'b0;
  bit squeeze_done  = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the model by one bus word and return the result it must produce.
  function automatic vri_rsp_t reg_file_step(input vri_req_t w);
    vri_rsp_t r;
    logic     wr;
    logic [4:0] pi;
    r  = '0;
    wr = (w.command == CMD_WRITE);
    if (w.command == CMD_STATUS) begin
      vblank_q = w.status_flags[2];
      hit_q    = w.status_flags[1];
      ovf_q    = w.status_flags[0];
    end else if (w.command == CMD_READ || w.command == CMD_WRITE) begin
      case (w.reg_index)
        REG_CTRL0: begin
          if (wr) begin
            ctrl0_q = w.write_data;
            scroll_temp[11:10] = w.write_data[1:0];
          end else begin
            r.read_data = ctrl0_q;
          end
        end
        REG_CTRL1: begin
          if (wr) ctrl1_q = w.write_data;
          else r.read_data = ctrl1_q;
        end
        REG_STATUS: begin
          // overflow survives the read; vblank, hit and the toggle do not
          if (!wr) begin
            r.read_data = {vblank_q, hit_q, ovf_q, 5'b0} | STATUS_FIXED;
            vblank_q = 1'b0;
            hit_q    = 1'b0;
            wr_latch = 1'b0;
          end
        end
        REG_OBJ_ADDR: begin
          if (wr) oam_ptr = w.write_data;
        end
        REG_OBJ_DATA: begin
          if (wr) oam_mem[oam_ptr] = w.write_data;
          else r.read_data = oam_mem[oam_ptr];
          oam_ptr = oam_ptr + 8'd1;
        end
        REG_SCROLL: begin
          if (wr) begin
            if (!wr_latch) begin
              fine_x_q = w.write_data[2:0];
              scroll_temp[4:0] = w.write_data[7:3];
            end else begin
              scroll_temp[14:12] = w.write_data[2:0];
              scroll_temp[9:5]   = w.write_data[7:3];
            end
            wr_latch = ~wr_latch;
          end
        end
        REG_ADDR: begin
          if (wr) begin
            if (!wr_latch) begin
              acc_addr[14:8]    = w.write_data[6:0];
              scroll_temp[14:8] = {1'b0, w.write_data[5:0]};
            end else begin
              acc_addr[7:0]    = w.write_data;
              scroll_temp[7:0] = w.write_data;
              render_reg       = scroll_temp;
            end
            wr_latch = ~wr_latch;
          end
        end
        default: begin
          pi = acc_addr[4:0];
          if (pi == PAL_MIRROR) pi = '0;
          if (acc_addr[14:8] == PAL_PAGE) begin
            if (wr) pal_mem[pi] = w.write_data;
            else r.read_data = pal_mem[pi];
          end else if (wr) begin
            if (acc_addr >= 15'h2000 && acc_addr < 15'h3F00) begin
              r.vram_we    = 1'b1;
              r.vram_waddr = (acc_addr[13:0] & nt_mask_q) + NT_BASE;
              r.vram_wdata = w.write_data;
            end
          end else if (acc_addr < 15'h3F00) begin
            r.read_data = rd_buf;
            rd_buf = w.vram_data;
          end
          acc_addr = {1'b0, acc_addr[13:0] + (ctrl0_q[2] ? 14'd32 : 14'd1)};
        end
      endcase
    end
    r.vram_addr    = acc_addr;
    r.render_addr  = render_reg;
    r.fine_x       = fine_x_q;
    r.control_zero = ctrl0_q;
    r.control_one  = ctrl1_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [14:0] got_v,
                                 input logic [14:0] want_v);
    if (error_count < 40)
      $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, rsp_seen, what, got_v, want_v);
    error_count++;
  endtask

  task automatic check_result(input vri_rsp_t got, input vri_rsp_t want);
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
    if (got.vram_addr !== want.vram_addr)
      report_mismatch("vram_addr", got.vram_addr, want.vram_addr);
    if (got.vram_we !== want.vram_we)
      report_mismatch("vram_we", got.vram_we, want.vram_we);
    if (got.vram_waddr !== want.vram_waddr)
      report_mismatch("vram_waddr", got.vram_waddr, want.vram_waddr);
    if (got.vram_wdata !== want.vram_wdata)
      report_mismatch("vram_wdata", got.vram_wdata, want.vram_wdata);
    if (got.render_addr !== want.render_addr)
      report_mismatch("render_addr", got.render_addr, want.render_addr);
    if (got.fine_x !== want.fine_x)
      report_mismatch("fine_x", got.fine_x, want.fine_x);
    if (got.control_zero !== want.control_zero)
      report_mismatch("control_zero", got.control_zero, want.control_zero);
    if (got.control_one !== want.control_one)
      report_mismatch("control_one", got.control_one, want.control_one);
  endtask

  // Driver: on a handshake, advance the model; then offer the next word
  // unless this cycle is picked as an idle one. Valid is only ever assigned
  // once per edge, so a back-to-back offer keeps it high.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp.push_back(reg_file_step(req_ch.payload));
        words_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (bus_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.payload <= bus_words.pop_front();
          req_ch.valid   <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed so that the
  // output and input registers both fill and the request side backs up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (squeeze_armed && rsp_seen >= squeeze_mark) begin
        hold_left = 150;
        squeeze_armed = 1'b0;
        squeeze_done  = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("result with no word awaited", rsp_ch.payload.vram_addr, '0);
      end else begin
        check_result(rsp_ch.payload, awaited_rsp.pop_front());
      end
      if (rsp_ch.payload.vram_we) nt_writes++;
      rsp_seen++;
    end
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [2:0] idx,
                            input logic [7:0] d);
    vri_req_t w;
    w.command      = cmd;
    w.reg_index    = idx;
    w.write_data   = d;
    w.vram_data    = 8'($urandom);
    w.status_flags = 3'($urandom);
    bus_words.push_back(w);
    words_issued++;
  endtask

  // One short, well-formed access pattern with random content, or noise.
  task automatic queue_random_sequence();
    int pick;
    logic [7:0] hi;
    logic [1:0] dir;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // point the access address somewhere, then hammer the data port
      queue_word(CMD_READ, REG_STATUS, 8'($urandom));
      if ($urandom_range(0, 3) == 0) queue_word(CMD_WRITE, REG_CTRL0, 8'($urandom));
      case ($urandom_range(0, 9))
        0, 1, 2:    hi = 8'h3F;
        3, 4, 5, 6: hi = 8'($urandom_range(8'h20, 8'h3E));
        7, 8:       hi = 8'($urandom_range(8'h00, 8'h1F));
        default:    hi = 8'($urandom_range(8'h40, 8'h7F));
      endcase
      hi[7] = 1'($urandom);
      queue_word(CMD_WRITE, REG_ADDR, hi);
      queue_word(CMD_WRITE, REG_ADDR, 8'($urandom));
      repeat ($urandom_range(1, 6)) begin
        dir = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        queue_word(dir, REG_DATA, 8'($urandom));
      end
    end else if (pick < 55) begin
      if ($urandom_range(0, 1)) queue_word(CMD_READ, REG_STATUS, 8'($urandom));
      queue_word(CMD_WRITE, REG_SCROLL, 8'($urandom));
      queue_word(CMD_WRITE, REG_SCROLL, 8'($urandom));
    end else if (pick < 70) begin
      queue_word(CMD_WRITE, REG_OBJ_ADDR, 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
        dir = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        queue_word(dir, REG_OBJ_DATA, 8'($urandom));
      end
    end else if (pick < 80) begin
      queue_word(CMD_STATUS, 3'($urandom), 8'($urandom));
      queue_word(CMD_READ, REG_STATUS, 8'($urandom));
    end else if (pick < 88) begin
      dir = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      queue_word(dir, $urandom_range(0, 1) ? REG_CTRL1 : REG_CTRL0, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3))
        queue_word(2'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_segment();
    int start;
    start = words_issued;
    while (words_issued - start < SEGMENT_WORDS) queue_random_sequence();
  endtask

  // Wait until every issued word has come back, then let the pipe settle.
  task automatic drain();
    while (rsp_seen != words_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_nt_mask(input logic [13:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    nt_mask_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus sequencing: directed words first, then six random segments,
  // each under its own mask, with the three idling profiles taken by two segments each.
  initial begin
    logic [13:0] seg_mask [6];
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    foreach (oam_mem[i]) oam_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    seg_mask[0] = 14'h3FFF;
    seg_mask[1] = 14'h0000;
    seg_mask[2] = 14'($urandom);
    seg_mask[3] = 14'h07FF;
    seg_mask[4] = 14'($urandom);
    seg_mask[5] = 14'h3FFF;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // status flags: reset view, load all, read-to-clear, overflow kept
    queue_word(CMD_READ, REG_STATUS, 8'h00);
    queue_word(CMD_STATUS, REG_CTRL0, 8'h00);
    bus_words[$].status_flags = 3'b111;
    queue_word(CMD_READ, REG_STATUS, 8'hFF);
    queue_word(CMD_READ, REG_STATUS, 8'h00);
    queue_word(CMD_WRITE, REG_STATUS, 8'hFF);
    // control bytes at both extremes
    queue_word(CMD_WRITE, REG_CTRL0, 8'hFF);
    queue_word(CMD_READ, REG_CTRL0, 8'h00);
    queue_word(CMD_WRITE, REG_CTRL1, 8'hFF);
    queue_word(CMD_READ, REG_CTRL1, 8'h00);
    // object address wraps past the top entry
    queue_word(CMD_WRITE, REG_OBJ_ADDR, 8'hFF);
    queue_word(CMD_WRITE, REG_OBJ_DATA, 8'hA5);
    queue_word(CMD_WRITE, REG_OBJ_ADDR, 8'hFF);
    queue_word(CMD_READ, REG_OBJ_DATA, 8'h00);
    // write-only registers read as zero
    queue_word(CMD_READ, REG_OBJ_ADDR, 8'h00);
    queue_word(CMD_READ, REG_SCROLL, 8'h00);
    queue_word(CMD_READ, REG_ADDR, 8'h00);
    // scroll pair at all ones, then palette entry 16 folding onto entry 0
    queue_word(CMD_WRITE, REG_SCROLL, 8'hFF);
    queue_word(CMD_WRITE, REG_SCROLL, 8'hFF);
    queue_word(CMD_WRITE, REG_ADDR, 8'h3F);
    queue_word(CMD_WRITE, REG_ADDR, 8'h10);
    queue_word(CMD_WRITE, REG_DATA, 8'hFF);
    queue_word(CMD_WRITE, REG_ADDR, 8'h3F);
    queue_word(CMD_WRITE, REG_ADDR, 8'h00);
    queue_word(CMD_READ, REG_DATA, 8'h00);
    // nametable write, then the top of the address space
    queue_word(CMD_WRITE, REG_ADDR, 8'h23);
    queue_word(CMD_WRITE, REG_ADDR, 8'hFF);
    queue_word(CMD_WRITE, REG_DATA, 8'h5A);
    queue_word(CMD_WRITE, REG_ADDR, 8'hFF);
    queue_word(CMD_WRITE, REG_ADDR, 8'hFF);
    queue_word(CMD_READ, REG_DATA, 8'h00);
    queue_word(CMD_READ, REG_DATA, 8'h00);
    queue_word(CMD_WRITE, REG_DATA, 8'h77);
    queue_word(CMD_NONE, REG_DATA, 8'hFF);
    drain();

    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin send_idle_pct = 19; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_nt_mask(seg_mask[s]);
      if (s == 4) begin
        // hold the receiver off while the sender keeps offering
        squeeze_mark  = rsp_seen + 20;
        squeeze_armed = 1'b1;
      end
      queue_segment();
      drain();
    end

    repeat (8) @(posedge clk);
    if (awaited_rsp.size() != 0)
      report_mismatch("expectations left over", 15'(awaited_rsp.size()), '0);

    $display("Covered %0d bus words (%0d nametable writes) across 7 mask settings,",
             words_sent, nt_writes);
    $display("three idling profiles and %0s long result stall.",
             squeeze_done ? "one" : "no");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous bound: the slowest profile needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("Timeout with %0d of %0d results seen", rsp_seen, words_issued);
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/vri_pkg.sv
hw/rtl/vri_req_if.sv
hw/rtl/vri_rsp_if.sv
hw/rtl/vri_object_ram.sv
hw/rtl/vri_reg_core.sv
hw/rtl/video_register_interface.sv
dv/video_register_interface_tb.sv
